### rtl/core/separable_field_force_accumulator_macros.svh
// assertion macros for the separable field force accumulator
// included by the files that carry concurrent checks, no other dependencies
`ifndef SEPARABLE_FIELD_FORCE_ACCUMULATOR_MACROS_SVH
`define SEPARABLE_FIELD_FORCE_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, reset held low disables the check
`define SFFA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sffa check failed");
// next-cycle implication
`define SFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sffa check failed");
`else
`define SFFA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/sffa_pkg.sv
// shared widths, constants and controller/datapath command types
// no dependencies
package sffa_pkg;

	localparam int COEF_W   = 16;
	localparam int FIELD_W  = 32;
	localparam int PP_W     = 2 * COEF_W;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 64;
	localparam int SUM_W    = 56;
	localparam int SUM_LO_W = 32;
	localparam int SUM_HI_W = SUM_W - SUM_LO_W;
	localparam int TERM_SHIFT = 22;
	localparam int OUT_SHIFT  = 24;
	localparam int RND_W    = PROD_W - OUT_SHIFT;
	localparam int GRAD_W   = 32;
	localparam int IN_DATA_W  = 2 * COEF_W + 3 * FIELD_W;
	localparam int OUT_DATA_W = 2 * GRAD_W;

	localparam logic [PROD_W-1:0] TERM_RND = PROD_W'(1) << (TERM_SHIFT - 1);
	localparam logic [PROD_W-1:0] OUT_RND  = PROD_W'(1) << (OUT_SHIFT - 1);
	localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'h0000_0000_8000_0000);
	localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(64'h0000_0000_7FFF_FFFF);
	localparam logic [GRAD_W-1:0] GRAD_MIN = 32'h8000_0000;
	localparam logic [GRAD_W-1:0] GRAD_MAX = 32'h7FFF_FFFF;

	// operand pairing of the per-lane multiplier
	typedef enum logic [1:0] {
		MUL_TERM = 2'd0,
		MUL_LO   = 2'd1,
		MUL_HI   = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     pp_en;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     mag_en;
		logic     rnd_en;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic last_term;
	} sts_t;

endpackage

### rtl/core/sffa_lane.sv
// one force lane: term multiply, running sum, scale, round and saturate
// depends on sffa_pkg
module sffa_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sffa_pkg::cmd_t                      cmd,
	input  logic signed [sffa_pkg::PP_W-1:0]    pp,
	input  logic signed [sffa_pkg::FIELD_W-1:0] field,
	input  logic                                first_term,
	input  logic [sffa_pkg::FIELD_W-1:0]        ratio_mag,
	input  logic                                ratio_neg,
	output logic [sffa_pkg::GRAD_W-1:0]         grad,
	output logic                                sat
);

	logic signed [sffa_pkg::MUL_W-1:0]   op_a;
	logic signed [sffa_pkg::MUL_W-1:0]   op_b;
	logic signed [2*sffa_pkg::MUL_W-1:0] mul_full;
	logic [sffa_pkg::PROD_W-1:0]         prod_q;
	logic [sffa_pkg::SUM_W-1:0]          sum_q;
	logic [sffa_pkg::SUM_W-1:0]          ms_q;
	logic                                neg_q;
	logic [sffa_pkg::RND_W-1:0]          rnd_q;
	logic [sffa_pkg::PROD_W-1:0]         term_rnd;
	logic [sffa_pkg::SUM_W-1:0]          term;
	logic [sffa_pkg::PROD_W-1:0]         out_rnd;
	logic [sffa_pkg::PROD_W-1:0]         mag;

	always_comb begin
		unique case (cmd.mul_sel)
			sffa_pkg::MUL_TERM: begin
				op_a = sffa_pkg::MUL_W'(pp);
				op_b = sffa_pkg::MUL_W'(field);
			end
			sffa_pkg::MUL_LO: begin
				op_a = {1'b0, ms_q[sffa_pkg::SUM_LO_W-1:0]};
				op_b = {1'b0, ratio_mag};
			end
			sffa_pkg::MUL_HI: begin
				op_a = {{(sffa_pkg::MUL_W - sffa_pkg::SUM_HI_W){1'b0}},
					ms_q[sffa_pkg::SUM_W-1:sffa_pkg::SUM_LO_W]};
				op_b = {1'b0, ratio_mag};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_full = op_a * op_b;

	// round the q.46 product to q.24, ties up
	assign term_rnd = prod_q + sffa_pkg::TERM_RND;
	assign term     = {{(sffa_pkg::SUM_W - (sffa_pkg::PROD_W - sffa_pkg::TERM_SHIFT))
		{term_rnd[sffa_pkg::PROD_W-1]}}, term_rnd[sffa_pkg::PROD_W-1:sffa_pkg::TERM_SHIFT]};

	assign out_rnd = prod_q + sffa_pkg::OUT_RND;

	// high partial product sits 8 bits up against the rounded low one
	assign mag = {prod_q[sffa_pkg::SUM_W-1:0], {(sffa_pkg::PROD_W - sffa_pkg::SUM_W){1'b0}}}
		+ {{(sffa_pkg::PROD_W - sffa_pkg::RND_W){1'b0}}, rnd_q};

	always_comb begin
		if (neg_q) begin
			sat  = mag > sffa_pkg::NEG_LIMIT;
			grad = sat ? sffa_pkg::GRAD_MIN : (sffa_pkg::GRAD_W'(0) - mag[sffa_pkg::GRAD_W-1:0]);
		end else begin
			sat  = mag > sffa_pkg::POS_LIMIT;
			grad = sat ? sffa_pkg::GRAD_MAX : mag[sffa_pkg::GRAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= first_term ? term : (sum_q + term);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_full[sffa_pkg::PROD_W-1:0];
		end
		if (cmd.mag_en) begin
			ms_q  <= sum_q[sffa_pkg::SUM_W-1] ? (sffa_pkg::SUM_W'(0) - sum_q) : sum_q;
			neg_q <= sum_q[sffa_pkg::SUM_W-1] ^ ratio_neg;
		end
		if (cmd.rnd_en) begin
			rnd_q <= out_rnd[sffa_pkg::PROD_W-1:sffa_pkg::OUT_SHIFT];
		end
	end

endmodule

### rtl/core/sffa_datapath.sv
// datapath: input capture, coefficient product, two force lanes, result register
// depends on sffa_pkg and sffa_lane
module sffa_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sffa_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	input  sffa_pkg::cmd_t                      cmd,
	output sffa_pkg::sts_t                      sts,
	output logic [sffa_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tuser
);

	logic signed [sffa_pkg::COEF_W-1:0]  px_q;
	logic signed [sffa_pkg::COEF_W-1:0]  py_q;
	logic signed [sffa_pkg::FIELD_W-1:0] fx_q;
	logic signed [sffa_pkg::FIELD_W-1:0] fy_q;
	logic [sffa_pkg::FIELD_W-1:0]        ratio_q;
	logic                                first_q;
	logic                                last_q;
	logic signed [sffa_pkg::PP_W-1:0]    pp_q;
	logic [sffa_pkg::FIELD_W-1:0]        rmag_q;
	logic [sffa_pkg::GRAD_W-1:0]         grad_x;
	logic [sffa_pkg::GRAD_W-1:0]         grad_y;
	logic                                sat_x;
	logic                                sat_y;
	logic [sffa_pkg::GRAD_W-1:0]         grad_x_q;
	logic [sffa_pkg::GRAD_W-1:0]         grad_y_q;
	logic                                ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q    <= s_tdata[15:0];
			py_q    <= s_tdata[31:16];
			fx_q    <= s_tdata[63:32];
			fy_q    <= s_tdata[95:64];
			ratio_q <= s_tdata[127:96];
			first_q <= s_tuser;
			last_q  <= s_tlast;
		end
		if (cmd.pp_en) begin
			pp_q <= px_q * py_q;
		end
		if (cmd.mag_en) begin
			rmag_q <= ratio_q[sffa_pkg::FIELD_W-1] ? (sffa_pkg::FIELD_W'(0) - ratio_q) : ratio_q;
		end
		if (cmd.load_out) begin
			grad_x_q <= grad_x;
			grad_y_q <= grad_y;
			ovf_q    <= sat_x | sat_y;
		end
	end

	sffa_lane u_lane_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.pp         (pp_q),
		.field      (fx_q),
		.first_term (first_q),
		.ratio_mag  (rmag_q),
		.ratio_neg  (ratio_q[sffa_pkg::FIELD_W-1]),
		.grad       (grad_x),
		.sat        (sat_x)
	);

	sffa_lane u_lane_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.pp         (pp_q),
		.field      (fy_q),
		.first_term (first_q),
		.ratio_mag  (rmag_q),
		.ratio_neg  (ratio_q[sffa_pkg::FIELD_W-1]),
		.grad       (grad_y),
		.sat        (sat_y)
	);

	assign sts.last_term = last_q;
	assign m_tdata = {grad_y_q, grad_x_q};
	assign m_tuser = ovf_q;

endmodule

### rtl/core/sffa_ctrl.sv
// controller: sequences one term through the datapath, owns both handshakes
// depends on sffa_pkg
module sffa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  sffa_pkg::sts_t sts,
	output sffa_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PP   = 8'b0000_0010,
		ST_MUL  = 8'b0000_0100,
		ST_ACC  = 8'b0000_1000,
		ST_MAG  = 8'b0001_0000,
		ST_LO   = 8'b0010_0000,
		ST_HI   = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   valid_q;
	logic   out_free;

	assign out_free = !valid_q || m_tready;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = sffa_pkg::MUL_TERM;
		s_tready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_PP;
				end
			end
			ST_PP: begin
				cmd.pp_en = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = sts.last_term ? ST_MAG : ST_IDLE;
			end
			ST_MAG: begin
				cmd.mag_en = 1'b1;
				state_d    = ST_LO;
			end
			ST_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = sffa_pkg::MUL_LO;
				state_d     = ST_HI;
			end
			ST_HI: begin
				cmd.rnd_en  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = sffa_pkg::MUL_HI;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;

endmodule

### rtl/core/separable_field_force_accumulator.sv
// top level of the separable field force accumulator; depends on sffa_pkg,
// sffa_ctrl, sffa_datapath (with sffa_lane) and the assertion macro header
//
// the slave channel takes one basis-pair term per transaction: tdata holds
// px_coef, py_coef, field_x, field_y and cell_scale, tuser is first_term and
// tlast is last_term. each term adds px*py*field into the x and y sums;
// first_term restarts both sums with the term itself
// a term with last_term set yields one master transaction: grad_x and
// grad_y (sum times cell_scale, rounded, saturated to 32 bits) in tdata and
// the overflow flag in tuser
// a term that closes no cell passes the product, multiply and accumulate states
// before tready rises again; a closing term also passes the magnitude, low,
// high and final states before m_tvalid rises, and the next term is taken
// once the result is loaded. no term is taken while one is in work, as the
// multiplier per lane is used in turn for the term product and for the two
// halves of the 56 by 32 bit scale, with a register after each use
// reset clears both sums and drops m_tvalid. the result waits in an output
// register, so a stalled receiver does not stop the following terms; only a
// second closing term waits until the first result has been taken
`include "separable_field_force_accumulator_macros.svh"

module separable_field_force_accumulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// px_coef [15:0], py_coef [31:16], field_x [63:32], field_y [95:64], cell_scale [127:96]
	input  logic [sffa_pkg::IN_DATA_W-1:0]      s_tdata,
	// first_term
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// grad_x [31:0], grad_y [63:32]
	output logic [sffa_pkg::OUT_DATA_W-1:0]     m_tdata,
	// overflow
	output logic                                m_tuser
);

	// command and status between the sequencer and the arithmetic
	sffa_pkg::cmd_t cmd;
	sffa_pkg::sts_t sts;

	sffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sffa_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// a term occupies the block after its transaction, with tready low
	`SFFA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a fresh result only comes out of the final scaling step
	`SFFA_ASSERT_IMPLIES(a_result_after_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

	// overflow flag only with a clamped value on one of the two outputs
	`SFFA_ASSERT_IMPLIES(a_overflow_clamped, clk, arst_n, m_tvalid && m_tuser,
		m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
		m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000)

endmodule
